[hdl/pwl_pkg.sv]
// Package for the piecewise linear interpolator: shared types, codes and defaults.
// Used by the controller, datapath, top level and checkers.
package pwl_pkg;

  localparam int MAX_POINTS_DEF = 64;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_PROBE,
    RD_LO,
    RD_LO1,
    RD_IDXM1
  } rd_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH,
    S_SWAIT,
    S_L_CHK,
    S_L_CHKW,
    S_L_FULL,
    S_L_SHIFT,
    S_L_SHW,
    S_Q_RD0,
    S_Q_RD1,
    S_Q_DIFF,
    S_Q_MUL0,
    S_Q_MUL1,
    S_Q_MSUM,
    S_Q_DIV,
    S_Q_FIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    clear;
    logic    srch_init;
    logic    srch_upd;
    logic    x0_cap;
    logic    diff_cap;
    logic    mul_lo;
    logic    mul_hi;
    logic    div_init;
    logic    div_step;
    logic    fin_calc;
    logic    idx_init;
    logic    shift_wr;
    logic    ins_wr;
    logic    res_set;
    status_t res_code;
    logic    out_load;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic lo_lt_hi;
    logic lo_lt_cnt;
    logic x_eq_rd;
    logic cnt_full;
    logic cnt_lt2;
    logic idx_gt_lo;
    logic div_last;
  } sts_t;

endpackage

[hdl/pwl_in_if.sv]
// Input channel of the interpolator: valid/ready handshake with the item payload.
// Depends on nothing but the clock domain of its user.
interface pwl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;

  modport source (output valid, action, coord_x, coord_y, input ready);
  modport sink   (input valid, action, coord_x, coord_y, output ready);
endinterface

[hdl/pwl_out_if.sv]
// Result channel of the interpolator: valid/ready handshake with value and status.
// Depends on nothing but the clock domain of its user.
interface pwl_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value;
  logic [1:0]  status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

[hdl/pwl_ctrl.sv]
// Controller state machine of the interpolator: sequences search, insertion and
// interpolation steps. Depends on pwl_pkg (state, command and status types).
module pwl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pwl_pkg::sts_t   sts,
  output pwl_pkg::cmd_t   cmd
);

  pwl_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.res_code  = pwl_pkg::ST_OK;
    cmd.rd_sel    = pwl_pkg::RD_PROBE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      pwl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = pwl_pkg::S_DISPATCH;
        end
      end
      pwl_pkg::S_DISPATCH: begin
        unique case (sts.act)
          pwl_pkg::ACT_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.res_set = 1'b1;
            state_nxt   = pwl_pkg::S_FINISH;
          end
          pwl_pkg::ACT_LOAD: begin
            cmd.srch_init = 1'b1;
            state_nxt     = pwl_pkg::S_SRCH;
          end
          pwl_pkg::ACT_QUERY: begin
            if (sts.cnt_lt2) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = pwl_pkg::ST_SHORT;
              state_nxt    = pwl_pkg::S_FINISH;
            end else begin
              cmd.srch_init = 1'b1;
              state_nxt     = pwl_pkg::S_SRCH;
            end
          end
          default: begin
            cmd.res_set = 1'b1;
            state_nxt   = pwl_pkg::S_FINISH;
          end
        endcase
      end
      pwl_pkg::S_SRCH: begin
        if (sts.lo_lt_hi) begin
          cmd.rd_sel = pwl_pkg::RD_PROBE;
          state_nxt  = pwl_pkg::S_SWAIT;
        end else if (sts.act == pwl_pkg::ACT_LOAD) begin
          state_nxt = pwl_pkg::S_L_CHK;
        end else begin
          state_nxt = pwl_pkg::S_Q_RD0;
        end
      end
      pwl_pkg::S_SWAIT: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = pwl_pkg::S_SRCH;
      end
      pwl_pkg::S_L_CHK: begin
        // The lower bound is the only stored point that can equal the new abscissa.
        if (sts.lo_lt_cnt) begin
          cmd.rd_sel = pwl_pkg::RD_LO;
          state_nxt  = pwl_pkg::S_L_CHKW;
        end else begin
          state_nxt = pwl_pkg::S_L_FULL;
        end
      end
      pwl_pkg::S_L_CHKW: begin
        if (sts.x_eq_rd) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = pwl_pkg::ST_DUP;
          state_nxt    = pwl_pkg::S_FINISH;
        end else begin
          state_nxt = pwl_pkg::S_L_FULL;
        end
      end
      pwl_pkg::S_L_FULL: begin
        if (sts.cnt_full) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = pwl_pkg::ST_FULL;
          state_nxt    = pwl_pkg::S_FINISH;
        end else begin
          cmd.idx_init = 1'b1;
          state_nxt    = pwl_pkg::S_L_SHIFT;
        end
      end
      pwl_pkg::S_L_SHIFT: begin
        if (sts.idx_gt_lo) begin
          cmd.rd_sel = pwl_pkg::RD_IDXM1;
          state_nxt  = pwl_pkg::S_L_SHW;
        end else begin
          cmd.ins_wr  = 1'b1;
          cmd.res_set = 1'b1;
          state_nxt   = pwl_pkg::S_FINISH;
        end
      end
      pwl_pkg::S_L_SHW: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = pwl_pkg::S_L_SHIFT;
      end
      pwl_pkg::S_Q_RD0: begin
        cmd.rd_sel = pwl_pkg::RD_LO;
        state_nxt  = pwl_pkg::S_Q_RD1;
      end
      pwl_pkg::S_Q_RD1: begin
        cmd.x0_cap = 1'b1;
        cmd.rd_sel = pwl_pkg::RD_LO1;
        state_nxt  = pwl_pkg::S_Q_DIFF;
      end
      pwl_pkg::S_Q_DIFF: begin
        cmd.diff_cap = 1'b1;
        state_nxt    = pwl_pkg::S_Q_MUL0;
      end
      pwl_pkg::S_Q_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = pwl_pkg::S_Q_MUL1;
      end
      pwl_pkg::S_Q_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = pwl_pkg::S_Q_MSUM;
      end
      pwl_pkg::S_Q_MSUM: begin
        cmd.div_init = 1'b1;
        state_nxt    = pwl_pkg::S_Q_DIV;
      end
      pwl_pkg::S_Q_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = pwl_pkg::S_Q_FIN;
        end
      end
      pwl_pkg::S_Q_FIN: begin
        cmd.fin_calc = 1'b1;
        state_nxt    = pwl_pkg::S_FINISH;
      end
      pwl_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pwl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pwl_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/pwl_dp.sv]
// Datapath of the interpolator: point memory, search bounds, multiplier,
// serial divider and result registers. Depends on pwl_pkg.
module pwl_dp #(
  parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pwl_pkg::cmd_t      cmd,
  output pwl_pkg::sts_t      sts,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [63:0]        mem [MAX_POINTS];
  logic [63:0]        rd_r;
  pwl_pkg::act_t      act_r;
  logic signed [31:0] x_r, y_r, x0_r, y0_r;
  logic [CW-1:0]      cnt_r, lo_r, hi_r, idx_r;
  logic [32:0]        a_r, b_r, den_r;
  logic               neg_r;
  logic [49:0]        plo_r;
  logic [48:0]        phi_r;
  logic [63:0]        quo_r;
  logic [32:0]        rem_r;
  logic [5:0]         dcnt_r;
  logic signed [31:0] res_value_r, out_value_r;
  pwl_pkg::status_t   res_status_r, out_status_r;

  logic [CW:0]        bsum;
  logic [CW-1:0]      mid, raddr, waddr;
  logic signed [31:0] rd_x, rd_y;
  logic signed [32:0] dx, dy;
  logic [33:0]        rem_sh;
  logic               ge;
  logic [40:0]        qc;
  logic signed [42:0] fsum;
  logic signed [31:0] fsat;
  logic               we;
  logic [63:0]        wdata;

  assign bsum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid  = bsum[CW:1];
  assign rd_x = rd_r[63:32];
  assign rd_y = rd_r[31:0];

  always_comb begin
    case (cmd.rd_sel)
      pwl_pkg::RD_PROBE: raddr = (act_r == pwl_pkg::ACT_QUERY) ? mid + CW'(1) : mid;
      pwl_pkg::RD_LO:    raddr = lo_r;
      pwl_pkg::RD_LO1:   raddr = lo_r + CW'(1);
      default:           raddr = idx_r - CW'(1);
    endcase
  end

  assign we    = cmd.shift_wr | cmd.ins_wr;
  assign waddr = cmd.shift_wr ? idx_r : lo_r;
  assign wdata = cmd.shift_wr ? rd_r : {x_r, y_r};

  always_ff @(posedge clk) begin
    rd_r <= mem[raddr[AW-1:0]];
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
  end

  // Difference terms of the segment; entry lo+1 sits in the read register.
  assign dx = {x_r[31], x_r} - {x0_r[31], x0_r};
  assign dy = {rd_y[31], rd_y} - {y0_r[31], y0_r};

  // One restoring division step per cycle; the dividend shifts out of quo_r.
  assign rem_sh = {rem_r, quo_r[63]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    if (quo_r > 64'(41'h100_0000_0000)) begin
      qc = 41'h100_0000_0000;
    end else begin
      qc = quo_r[40:0];
    end
    fsum = 43'(y0_r) + (neg_r ? -$signed({2'b00, qc}) : $signed({2'b00, qc}));
    if (fsum > 43'sd2147483647) begin
      fsat = 32'sh7FFF_FFFF;
    end else if (fsum < -43'sd2147483648) begin
      fsat = 32'sh8000_0000;
    end else begin
      fsat = fsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clear) begin
      cnt_r <= '0;
    end else if (cmd.ins_wr) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= pwl_pkg::act_t'(in_action);
      x_r   <= in_coord_x;
      y_r   <= in_coord_y;
    end
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= (act_r == pwl_pkg::ACT_QUERY) ? cnt_r - CW'(2) : cnt_r;
    end else if (cmd.srch_upd) begin
      if (x_r <= rd_x) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid + CW'(1);
      end
    end
    if (cmd.idx_init) begin
      idx_r <= cnt_r;
    end else if (cmd.shift_wr) begin
      idx_r <= idx_r - CW'(1);
    end
    if (cmd.x0_cap) begin
      x0_r <= rd_x;
      y0_r <= rd_y;
    end
    if (cmd.diff_cap) begin
      a_r   <= dx[32] ? -dx : dx;
      b_r   <= dy[32] ? -dy : dy;
      neg_r <= dx[32] ^ dy[32];
      den_r <= {rd_x[31], rd_x} - {x0_r[31], x0_r};
    end
    if (cmd.mul_lo) begin
      plo_r <= a_r * b_r[16:0];
    end
    if (cmd.mul_hi) begin
      phi_r <= a_r * b_r[32:17];
    end
    if (cmd.div_init) begin
      quo_r  <= 64'(plo_r) + (64'(phi_r) << 17);
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? 33'(rem_sh - {1'b0, den_r}) : rem_sh[32:0];
      quo_r  <= {quo_r[62:0], ge};
      dcnt_r <= dcnt_r + 6'd1;
    end
    if (cmd.res_set) begin
      res_value_r  <= '0;
      res_status_r <= cmd.res_code;
    end else if (cmd.fin_calc) begin
      res_value_r  <= fsat;
      res_status_r <= pwl_pkg::ST_OK;
    end
    if (cmd.out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign sts.act       = act_r;
  assign sts.lo_lt_hi  = lo_r < hi_r;
  assign sts.lo_lt_cnt = lo_r < cnt_r;
  assign sts.x_eq_rd   = x_r == rd_x;
  assign sts.cnt_full  = cnt_r == CW'(MAX_POINTS);
  assign sts.cnt_lt2   = cnt_r < CW'(2);
  assign sts.idx_gt_lo = idx_r > lo_r;
  assign sts.div_last  = dcnt_r == 6'd63;

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

[hdl/piecewise_linear_interpolator.sv]
// Piecewise linear interpolator, one item in flight at a time; a finished result
// waits in the output register while the next item is taken. A query uses the
// 64-step serial divider. Synchronous reset empties the table and the handshake
// state; the point memory itself is not cleared.
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pwl_in_if.sink      in_ch,
  pwl_out_if.source   out_ch
);

  pwl_pkg::cmd_t cmd;
  pwl_pkg::sts_t sts;

  pwl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pwl_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (in_ch.action),
    .in_coord_x (in_ch.coord_x),
    .in_coord_y (in_ch.coord_y),
    .out_value  (out_ch.value),
    .out_status (out_ch.status)
  );

endmodule

[hdl/pwl_checker.sv]
// Port-level assertions for the interpolator, attached to the top level by bind.
// Depends on pwl_pkg for the status codes.
module pwl_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_status))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pwl_pkg::ST_OK |-> out_value == 32'd0)
    else $error("failed item returned a nonzero value");

endmodule

bind piecewise_linear_interpolator pwl_props u_pwl_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_status (out_ch.status)
);

[bench/pwl_checker.sv]
// Checker for the piecewise linear interpolator: watches both channels, keeps its
// own breakpoint table, predicts each result and compares. Depends on pwl_pkg and
// on the pwl_in_if and pwl_out_if interfaces.
`timescale 1ns / 100ps
module pwl_checker
  import pwl_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  pwl_in_if    in_ch,
  pwl_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic signed [31:0] value;
    status_t            status;
  } interp_res_t;

  logic signed [31:0] tbl_x [MAX_POINTS];
  logic signed [31:0] tbl_y [MAX_POINTS];
  int unsigned        tbl_count;
  interp_res_t        res_q [$];

  // Linear evaluation on segment i, saturated to 32 bits.
  function automatic logic signed [31:0] seg_value(int unsigned i, longint qx);
    longint   dx, dy, den, sum;
    bit       neg;
    bit [63:0] a, b, q;
    dx  = qx - longint'(tbl_x[i]);
    dy  = longint'(tbl_y[i + 1]) - longint'(tbl_y[i]);
    den = longint'(tbl_x[i + 1]) - longint'(tbl_x[i]);
    neg = (dx < 0) != (dy < 0);
    a   = (dx < 0) ? -dx : dx;
    b   = (dy < 0) ? -dy : dy;
    if (den <= 0) den = 1;
    q = (a * b) / 64'(den);
    if (q > 64'(1) << 40) q = 64'(1) << 40;
    sum = longint'(tbl_y[i]) + (neg ? -longint'(q) : longint'(q));
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  // Applies one item to the local table and returns the result it should give.
  function automatic interp_res_t apply_item(act_t act, logic signed [31:0] x,
                                             logic signed [31:0] y);
    interp_res_t r;
    bit          dup;
    int unsigned pos, lo, hi, mid;
    r.value  = '0;
    r.status = ST_OK;
    case (act)
      ACT_CLEAR: tbl_count = 0;
      ACT_LOAD: begin
        dup = 0;
        for (int unsigned k = 0; k < tbl_count; k++)
          if (tbl_x[k] == x) dup = 1;
        if (dup) r.status = ST_DUP;
        else if (tbl_count >= MAX_POINTS) r.status = ST_FULL;
        else begin
          pos = 0;
          while (pos < tbl_count && tbl_x[pos] < x) pos++;
          for (int unsigned k = tbl_count; k > pos; k--) begin
            tbl_x[k] = tbl_x[k - 1];
            tbl_y[k] = tbl_y[k - 1];
          end
          tbl_x[pos] = x;
          tbl_y[pos] = y;
          tbl_count++;
        end
      end
      ACT_QUERY: begin
        if (tbl_count < 2) r.status = ST_SHORT;
        else begin
          lo = 0;
          hi = tbl_count - 2;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (x <= tbl_x[mid + 1]) hi = mid;
            else lo = mid + 1;
          end
          r.value = seg_value(lo, longint'(x));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    interp_res_t want;
    if (!rst_n) begin
      tbl_count = 0;
      res_q.delete();
      fail_count <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (res_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result transfer with nothing expected: value %h status %0d",
                     $time, out_ch.value, out_ch.status);
          fail_count <= fail_count + 1;
        end else begin
          want = res_q.pop_front();
          if (out_ch.value !== want.value || out_ch.status !== want.status) begin
            if (fail_count < 10)
              $display("%0t: mismatch: expected value %h status %0d, got value %h status %0d",
                       $time, want.value, want.status, out_ch.value, out_ch.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        res_q.push_back(apply_item(act_t'(in_ch.action), in_ch.coord_x, in_ch.coord_y));
    end
    pending <= res_q.size();
  end

endmodule

[bench/tb.sv]
// Top of the interpolator testbench: clock, reset, item stimulus, result-side
// flow control and the verdict. Depends on pwl_pkg, the channel interfaces,
// the block piecewise_linear_interpolator and the checker pwl_checker.
`timescale 1ns / 100ps
module tb;
  import pwl_pkg::*;

  localparam int  ITEM_TARGET = 1950;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  HOLD_CYCLES = 400;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending;
  int   cycles = 0;
  int   n_sent = 0, n_clear = 0, n_load = 0, n_query = 0, n_other = 0;
  bit   tx_eager = 0, rx_eager = 0;
  int   hold_reqs = 0, hold_done = 0;
  int   hold_cnt = 0, wait_cnt = 0;

  pwl_in_if  in_ch ();
  pwl_out_if out_ch ();

  piecewise_linear_interpolator dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  pwl_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                   .fail_count(fail_count), .pending(pending));

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls per transfer, plus long hold-offs on request.
  always @(posedge clk) begin
    logic rdy;
    int   w;
    rdy = 1;
    if (!rst_n) rdy = 0;
    else if (hold_reqs != hold_done && hold_cnt == 0) begin
      hold_cnt = HOLD_CYCLES;
      hold_done++;
      rdy = 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      rdy = 0;
    end else if (wait_cnt > 0) begin
      wait_cnt--;
      rdy = 0;
    end else if (out_ch.valid && out_ch.ready) begin
      w = rx_eager ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        rdy = 0;
        wait_cnt = w - 1;
      end
    end
    out_ch.ready <= rdy;
  end

  task automatic send_item(act_t act, logic signed [31:0] x, logic signed [31:0] y);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1;
    in_ch.action  <= act;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    case (act)
      ACT_CLEAR: n_clear++;
      ACT_LOAD:  n_load++;
      ACT_QUERY: n_query++;
      default:   n_other++;
    endcase
  endtask

  // Coordinates: full-range, a narrow band around zero (to hit duplicates and
  // exact breakpoints), extremes, and single-bit patterns.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return ($signed($urandom_range(0, 64)) - 32) <<< 14;
      8: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'sh1 << $urandom_range(0, 31);
    endcase
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int npts, nq, kind;
    in_ch.valid   = 0;
    in_ch.action  = ACT_CLEAR;
    in_ch.coord_x = 0;
    in_ch.coord_y = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: empty and one-point queries, extremes, duplicates, code 3.
    send_item(ACT_QUERY, 0, 0);
    send_item(ACT_LOAD, 0, 32'sh00010000);
    send_item(ACT_QUERY, 0, 0);
    send_item(ACT_LOAD, 32'sh80000000, 32'sh7fffffff);
    send_item(ACT_LOAD, 32'sh7fffffff, 32'sh80000000);
    send_item(ACT_LOAD, 0, 5);
    send_item(ACT_LOAD, 32'sh7fffffff, 0);
    send_item(ACT_QUERY, 32'sh80000000, 0);
    send_item(ACT_QUERY, 32'sh7fffffff, 0);
    send_item(ACT_QUERY, 0, 0);
    send_item(ACT_QUERY, 32'sh40000000, 0);
    send_item(ACT_QUERY, -32'sh40000000, 0);
    send_item(ACT_NONE, 32'sh12345678, 32'sh9abcdef0);
    send_item(ACT_CLEAR, 32'shffffffff, 32'shffffffff);
    send_item(ACT_QUERY, 5, 0);
    send_item(ACT_LOAD, 32'sh00020000, 32'sh7fff0000);
    send_item(ACT_LOAD, 32'sh00010000, 32'sh80010000);
    send_item(ACT_QUERY, 0, 0);
    send_item(ACT_QUERY, 32'sh7fffffff, 0);
    send_item(ACT_QUERY, 32'sh80000000, 0);
    send_item(ACT_QUERY, 32'sh00018000, 0);
    send_item(ACT_CLEAR, 0, 0);

    while (n_sent < ITEM_TARGET) begin
      tx_eager = ($urandom_range(0, 4) == 0);
      rx_eager = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // Fill past capacity, then probe the full table.
        send_item(ACT_CLEAR, pick_coord(), pick_coord());
        for (int k = 0; k < 70; k++)
          send_item(ACT_LOAD, (k * 32'sh00030000) ^ ($urandom & 32'sh0000ffff), pick_coord());
        for (int k = 0; k < 8; k++) send_item(ACT_QUERY, pick_coord(), pick_coord());
      end else if (kind == 1) begin
        // Noise: any action code, any fields.
        for (int k = 0; k < 10; k++)
          send_item(act_t'($urandom_range(0, 3)), pick_coord(), pick_coord());
      end else begin
        npts = $urandom_range(0, 5) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 12);
        nq = $urandom_range(3, 20);
        send_item(ACT_CLEAR, pick_coord(), pick_coord());
        for (int k = 0; k < npts; k++) send_item(ACT_LOAD, pick_coord(), pick_coord());
        for (int k = 0; k < nq; k++) begin
          if ($urandom_range(0, 7) == 0) send_item(ACT_LOAD, pick_coord(), pick_coord());
          else send_item(ACT_QUERY, pick_coord(), pick_coord());
        end
      end
      if (kind == 2) begin
        // Receiver holds off while items keep coming, then a full drain.
        hold_reqs++;
        for (int k = 0; k < 12; k++) send_item(ACT_QUERY, pick_coord(), 0);
        wait_drained();
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("Sent %0d items: %0d clears, %0d loads, %0d queries, %0d unused codes,",
             n_sent, n_clear, n_load, n_query, n_other);
    $display("with random stalls on both sides, %0d long result hold-offs.", hold_done);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
